// ----- src/lcf_pkg.sv -----
// Shared constants, types and control codes for the convolution FIR core.
package lcf_pkg;

  localparam int MAX_TAPS     = 32;
  localparam int SAMPLE_WIDTH = 16;
  localparam int RESULT_WIDTH = 40;
  localparam int TAP_IDX_W    = 5;
  localparam int TAP_COUNT_W  = 6;
  localparam int CNT_W        = $clog2(MAX_TAPS + 1);
  localparam int SEL_W        = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  localparam logic CMD_TAP    = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } lcf_state_e;

  typedef struct packed {
    logic shift;
    logic zero_fill;
    logic clear;
    logic tap_we;
  } lcf_ctrl_t;

endpackage

// ----- src/linear_convolution_fir_core.sv -----
// Full linear convolution FIR core: a chain of tap cells, a sequencer and an output register.
//
// Each cell holds one delay-line sample and one kernel tap; a partial sum
// ripples down the chain one cell per cycle. After a sample transaction is
// accepted the sequencer waits for the ripple through the n effective taps,
// loads the output register once it is free and then returns to idle to take
// the next transaction, so a new sample waits until the last one's result is
// loaded. A last-marked sample is followed by n-1 zero-filled flush outputs,
// each with its own ripple and output load. A tap load is taken in idle. A
// finished result waits in the output register while the next transaction is
// taken. Tap count 0 acts as 1 and values above 32 act as 32.
module linear_convolution_fir_core import lcf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [TAP_COUNT_W-1:0]  cfg_wdata_i,    // tap_count
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [23:0]             s_axis_tdata,   // tap_index[4:0], value[20:5], zeros
  input  logic                    s_axis_tuser,   // cmd
  input  logic                    s_axis_tlast,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [RESULT_WIDTH-1:0] m_axis_tdata,   // result[39:0]
  output logic                    m_axis_tlast
);

  logic [TAP_COUNT_W-1:0]         tap_count_q;
  logic [CNT_W-1:0]               n_eff;
  logic [TAP_IDX_W-1:0]           in_tap_index;
  logic signed [SAMPLE_WIDTH-1:0] in_value;
  logic signed [SAMPLE_WIDTH-1:0] head_sample;
  lcf_ctrl_t                      ctrl;
  logic                           out_free;
  logic                           out_load;
  logic                           out_last;
  logic [SEL_W-1:0]               sel_idx;
  logic [CNT_W-1:0]               n_less;

  logic signed [SAMPLE_WIDTH-1:0] sample_w [MAX_TAPS];
  logic signed [RESULT_WIDTH-1:0] sum_w    [MAX_TAPS];

  logic                           out_valid_q;
  logic signed [RESULT_WIDTH-1:0] out_result_q;
  logic                           out_last_q;

  assign in_tap_index = s_axis_tdata[TAP_IDX_W-1:0];
  assign in_value     = s_axis_tdata[TAP_IDX_W +: SAMPLE_WIDTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAP_COUNT_W'(1);
    end else if (cfg_we_i) begin
      tap_count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (tap_count_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(tap_count_q) > MAX_TAPS) begin
      n_eff = CNT_W'(MAX_TAPS);
    end else begin
      n_eff = CNT_W'(tap_count_q);
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;

  lcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_last_i  (s_axis_tlast),
    .n_eff_i    (n_eff),
    .out_free_i (out_free),
    .in_ready_o (s_axis_tready),
    .ctrl_o     (ctrl),
    .out_load_o (out_load),
    .out_last_o (out_last)
  );

  assign head_sample = ctrl.zero_fill ? '0 : in_value;

  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic signed [RESULT_WIDTH-1:0] sum_in;

    if (j == 0) begin : g_head
      assign sample_in = head_sample;
      assign sum_in    = '0;
    end else begin : g_link
      assign sample_in = sample_w[j-1];
      assign sum_in    = sum_w[j-1];
    end

    lcf_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .tap_sel_i (int'(in_tap_index) == j),
      .value_i   (in_value),
      .sample_i  (sample_in),
      .sum_i     (sum_in),
      .sample_o  (sample_w[j]),
      .sum_o     (sum_w[j])
    );
  end

  assign n_less  = n_eff - CNT_W'(1);
  assign sel_idx = n_less[SEL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_result_q <= sum_w[sel_idx];
      out_last_q   <= out_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_result_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ----- src/lcf_cell.sv -----
// One tap cell: a delay-line sample, a kernel tap and a partial-sum stage.
module lcf_cell import lcf_pkg::*; (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lcf_ctrl_t                      ctrl_i,
  input  logic                           tap_sel_i,
  input  logic signed [SAMPLE_WIDTH-1:0] value_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic signed [RESULT_WIDTH-1:0] sum_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_o,
  output logic signed [RESULT_WIDTH-1:0] sum_o
);

  logic signed [SAMPLE_WIDTH-1:0]   sample_q, sample_d;
  logic signed [SAMPLE_WIDTH-1:0]   tap_q;
  logic signed [RESULT_WIDTH-1:0]   sum_q, sum_d;
  logic signed [2*SAMPLE_WIDTH-1:0] prod;

  always_comb begin
    sample_d = sample_q;
    if (ctrl_i.clear) begin
      sample_d = '0;
    end else if (ctrl_i.shift) begin
      sample_d = sample_i;
    end
  end

  assign prod  = sample_q * tap_q;
  assign sum_d = sum_i + RESULT_WIDTH'(prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else begin
      sample_q <= sample_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    if (ctrl_i.tap_we && tap_sel_i) begin
      tap_q <= value_i;
    end
  end

  assign sample_o = sample_q;
  assign sum_o    = sum_q;

endmodule

// ----- src/lcf_ctrl.sv -----
// Sequencer: takes input transactions, waits for the sum ripple, runs the flush.
module lcf_ctrl import lcf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_cmd_i,
  input  logic             in_last_i,
  input  logic [CNT_W-1:0] n_eff_i,
  input  logic             out_free_i,
  output logic             in_ready_o,
  output lcf_ctrl_t        ctrl_o,
  output logic             out_load_o,
  output logic             out_last_o
);

  lcf_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] flush_q, flush_d;
  logic             last_q, last_d;
  logic             accept;
  logic             done;

  assign accept = (state_q == ST_IDLE) && in_valid_i;
  assign done   = (state_q == ST_RUN) && (cnt_q == n_eff_i) && out_free_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    flush_d = flush_q;
    last_d  = last_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_cmd_i == CMD_SAMPLE)) begin
          state_d = ST_RUN;
          cnt_d   = '0;
          last_d  = in_last_i;
          flush_d = in_last_i ? (n_eff_i - CNT_W'(1)) : '0;
        end
      end
      ST_RUN: begin
        if (done) begin
          if (flush_q != '0) begin
            cnt_d   = '0;
            flush_d = flush_q - CNT_W'(1);
          end else begin
            state_d = ST_IDLE;
          end
        end else if (cnt_q != n_eff_i) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    ctrl_o     = '0;
    out_load_o = 1'b0;
    out_last_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          ctrl_o.shift  = (in_cmd_i == CMD_SAMPLE);
          ctrl_o.tap_we = (in_cmd_i == CMD_TAP);
        end
      end
      ST_RUN: begin
        if (done) begin
          out_load_o = 1'b1;
          out_last_o = last_q && (flush_q == '0);
          if (flush_q != '0) begin
            ctrl_o.shift     = 1'b1;
            ctrl_o.zero_fill = 1'b1;
          end else begin
            ctrl_o.clear = last_q;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      flush_q <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      flush_q <= flush_d;
      last_q  <= last_d;
    end
  end

endmodule

// ----- tb/sv/tb_linear_convolution_fir_core.sv -----
// Self-checking testbench for the convolution FIR core: streamed taps and samples against a predictor.
module tb_linear_convolution_fir_core import lcf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 5_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 350;

  class conv_scoreboard;
    logic signed [SAMPLE_WIDTH-1:0] delay_line[MAX_TAPS];
    logic signed [SAMPLE_WIDTH-1:0] kernel[MAX_TAPS];
    bit                             tap_written[MAX_TAPS];
    logic [TAP_COUNT_W-1:0]         tap_count;
    logic [RESULT_WIDTH-1:0]        exp_result_q[$];
    logic                           exp_last_q[$];
    int                             errors;
    int                             results_checked;
    int                             samples_seen;
    int                             taps_seen;
    int                             flushes_seen;

    function new();
      for (int i = 0; i < MAX_TAPS; i++) begin
        delay_line[i]  = '0;
        kernel[i]      = '0;
        tap_written[i] = 1'b0;
      end
      tap_count = TAP_COUNT_W'(1);
    endfunction

    function void set_tap_count(logic [TAP_COUNT_W-1:0] v);
      tap_count = v;
    endfunction

    function int active_taps();
      if (tap_count == 0) return 1;
      if (tap_count > MAX_TAPS) return MAX_TAPS;
      return int'(tap_count);
    endfunction

    function int pending();
      return exp_result_q.size();
    endfunction

    function void shift_sample(logic signed [SAMPLE_WIDTH-1:0] s);
      for (int i = MAX_TAPS - 1; i > 0; i--) delay_line[i] = delay_line[i-1];
      delay_line[0] = s;
    endfunction

    function logic [RESULT_WIDTH-1:0] dot_product(int n);
      logic signed [RESULT_WIDTH-1:0] acc;
      acc = '0;
      for (int j = 0; j < n; j++) acc = acc + delay_line[j] * kernel[j];
      return acc;
    endfunction

    function void note_input(logic cmd, logic [TAP_IDX_W-1:0] idx,
                             logic signed [SAMPLE_WIDTH-1:0] value, logic last);
      int n;
      if (cmd == CMD_TAP) begin
        kernel[idx]      = value;
        tap_written[idx] = 1'b1;
        taps_seen++;
        return;
      end
      n = active_taps();
      samples_seen++;
      shift_sample(value);
      exp_result_q.push_back(dot_product(n));
      exp_last_q.push_back(last && n == 1);
      if (last) begin
        flushes_seen++;
        for (int k = 1; k < n; k++) begin
          shift_sample('0);
          exp_result_q.push_back(dot_product(n));
          exp_last_q.push_back(k == n - 1);
        end
        for (int i = 0; i < MAX_TAPS; i++) delay_line[i] = '0;
      end
    endfunction

    function void check_result(logic [RESULT_WIDTH-1:0] data, logic last);
      logic [RESULT_WIDTH-1:0] exp_data;
      logic                    exp_last;
      if (exp_result_q.size() == 0) begin
        $display("%0t: unexpected result %h last %b", $time, data, last);
        errors++;
        return;
      end
      exp_data = exp_result_q.pop_front();
      exp_last = exp_last_q.pop_front();
      results_checked++;
      if (data !== exp_data) begin
        $display("%0t: result mismatch: expected %h actual %h", $time, exp_data, data);
        errors++;
      end
      if (last !== exp_last) begin
        $display("%0t: last mismatch: expected %b actual %b", $time, exp_last, last);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_we_i      = 1'b0;
  logic [TAP_COUNT_W-1:0]  cfg_wdata_i   = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [23:0]             s_axis_tdata  = '0;
  logic                    s_axis_tuser  = 1'b0;
  logic                    s_axis_tlast  = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [RESULT_WIDTH-1:0] m_axis_tdata;
  logic                    m_axis_tlast;

  conv_scoreboard sb = new();
  bit             quiet;
  int             stall_left;
  int             cycle_count;
  int             items_sent;
  int             settings_used;

  linear_convolution_fir_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'sh8000;
    if (r < 20) return 16'sh7fff;
    if (r < 25) return 16'sh0000;
    if (r < 30) return 16'shffff;
    return SAMPLE_WIDTH'($urandom());
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("linear_convolution_fir_core regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < 25) begin
      m_axis_tready <= 1'b0;
      stall_left    <= pick_gap();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  task automatic pause(int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_item(logic cmd, logic [TAP_IDX_W-1:0] idx,
                           logic signed [SAMPLE_WIDTH-1:0] value, logic last);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tlast  <= last;
    s_axis_tdata  <= {3'b000, value, idx};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    sb.note_input(cmd, idx, value, last);
    items_sent++;
    pause(pick_gap());
  endtask

  task automatic load_tap(logic [TAP_IDX_W-1:0] idx, logic signed [SAMPLE_WIDTH-1:0] value,
                          logic last = 1'b0);
    send_item(CMD_TAP, idx, value, last);
  endtask

  task automatic push_sample(logic signed [SAMPLE_WIDTH-1:0] value, logic last);
    send_item(CMD_SAMPLE, TAP_IDX_W'($urandom()), value, last);
  endtask

  task automatic write_tap_count(logic [TAP_COUNT_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_tap_count(v);
    settings_used++;
  endtask

  task automatic run_phase(int budget);
    int n;
    int seq_len;
    int start;
    start = items_sent;
    n     = sb.active_taps();
    quiet = ($urandom_range(0, 3) == 0);
    for (int j = 0; j < n; j++) begin
      if (!sb.tap_written[j]) load_tap(TAP_IDX_W'(j), pick_value());
    end
    while (items_sent - start < budget) begin
      if ($urandom_range(0, 99) < 15) begin
        load_tap(TAP_IDX_W'($urandom_range(0, MAX_TAPS - 1)), pick_value(),
                 1'($urandom_range(0, 1)));
      end else begin
        seq_len = $urandom_range(1, 6);
        for (int k = 0; k < seq_len; k++) begin
          if ($urandom_range(0, 9) == 0) load_tap(TAP_IDX_W'($urandom_range(0, n - 1)),
                                                  pick_value());
          push_sample(pick_value(), k == seq_len - 1 && $urandom_range(0, 4) != 0);
        end
      end
    end
  endtask

  initial begin
    logic [TAP_COUNT_W-1:0] phase_counts[8];
    logic [TAP_COUNT_W-1:0] next_count;
    int                     phase;
    phase_counts = '{6'd32, 6'd2, 6'd63, 6'd1, 6'd17, 6'd4, 6'd33, 6'd8};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    load_tap(0, 16'sh8000, 1'b1);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b1);
    load_tap(31, 16'sh7fff);
    push_sample(16'sh0000, 1'b1);

    write_tap_count(6'd0);
    push_sample(16'shffff, 1'b0);
    push_sample(16'sh0001, 1'b1);

    write_tap_count(6'd3);
    load_tap(1, 16'sh7fff);
    load_tap(2, 16'sh8000);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh8000, 1'b1);
    push_sample(16'sh5555, 1'b0);
    push_sample(16'shaaaa, 1'b1);

    items_sent = 0;
    phase      = 0;
    while (items_sent < RANDOM_ITEMS) begin
      next_count = (phase < 8) ? phase_counts[phase] : 6'($urandom_range(0, 63));
      write_tap_count(next_count);
      run_phase(35);
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d sample and %0d tap-load transactions, %0d flushed sequences",
             sb.samples_seen, sb.taps_seen, sb.flushes_seen);
    $display("checked %0d results across %0d tap-count settings, %0d errors",
             sb.results_checked, settings_used, sb.errors);
    if (sb.errors == 0) begin
      $display("linear_convolution_fir_core regression: pass");
    end else begin
      $display("linear_convolution_fir_core regression: fail");
    end
    $finish;
  end

endmodule
